// File: src/fpa_pkg.sv
// Package with the word format, opcodes and stage record of the Q24.8 fixed-point ALU.
`default_nettype none
package fpa_pkg;
    localparam int WordBits     = 32;
    localparam int FractionBits = 8;
    localparam int QuoBits      = WordBits + FractionBits;
    localparam int Stages       = QuoBits + 2;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_LE, OP_GE,
        OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_FROM_INT, OP_TO_INT
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic                    neg;
        logic [WordBits-1:0]     res;
        logic                    cmp;
        logic                    ovf;
        logic                    dz;
        logic [2*WordBits-1:0]   prod;
        logic [WordBits-1:0]     rem;
        logic [QuoBits-1:0]      num;
        logic [QuoBits-1:0]      quo;
        logic [WordBits-1:0]     den;
    } stage_t;
endpackage
`default_nettype wire

// File: src/fixed_point_q24_8_alu_top.sv
// Pipelined signed Q24.8 fixed-point ALU with a bit-per-stage divider.
//
//  Channel   Direction  tdata                          tuser
//  s_        in         [31:0] operand_a [63:32] b     [3:0] op
//  m_        out        [31:0] result_value            [0] compare_true [1] overflow
//                                                      [2] divide_by_zero
//
// Every operation passes through 42 register stages: one input stage, 40 divider
// stages that each retire one quotient bit, and one output stage that fits the word.
// One transfer is accepted per cycle while the output is not stalled.
// Reset clears the stage valid bits only. A stall on the output freezes all stages.
`default_nettype none
module fixed_point_q24_8_alu_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // operand_a, operand_b
    input  wire logic [3:0]  s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // result_value
    output logic [2:0]       m_tuser    // compare_true, overflow, divide_by_zero
);
    import fpa_pkg::*;

    localparam int W = WordBits;
    localparam int F = FractionBits;
    localparam int Q = QuoBits;
    localparam int N = Stages;

    stage_t            stg_reg  [N];
    stage_t            stg_next [N];
    logic   [N-1:0]    vld_reg;
    logic              adv;

    logic signed [W-1:0] a, b;
    logic signed [W:0]   sum_ab, dif_ab, inc_a, dec_a;
    logic [W-1:0]        ma, mb;
    logic                lt_ab, gt_ab;

    assign adv      = !vld_reg[N-1] || m_tready;
    assign s_tready = adv;

    always_comb begin
        a      = s_tdata[W-1:0];
        b      = s_tdata[2*W-1:W];
        sum_ab = {a[W-1], a} + {b[W-1], b};
        dif_ab = {a[W-1], a} - {b[W-1], b};
        inc_a  = {a[W-1], a} + {{W{1'b0}}, 1'b1};
        dec_a  = {a[W-1], a} - {{W{1'b0}}, 1'b1};
        ma     = a[W-1] ? (~a + {{(W-1){1'b0}}, 1'b1}) : a;
        mb     = b[W-1] ? (~b + {{(W-1){1'b0}}, 1'b1}) : b;
        lt_ab  = a < b;
        gt_ab  = b < a;
    end

    always_comb begin
        logic [W:0]     rs;
        logic           ge;
        logic [2*W-1:0] lim;
        stage_t         p;
        for (int k = 0; k < N; k++) begin
            stg_next[k] = stg_reg[k];
        end

        stg_next[0]      = '0;
        stg_next[0].op   = op_t'(s_tuser);
        stg_next[0].neg  = a[W-1] ^ b[W-1];
        stg_next[0].num  = {{F{1'b0}}, ma} << F;
        stg_next[0].prod = {{W{1'b0}}, ma};
        stg_next[0].den  = mb;
        unique case (op_t'(s_tuser))
            OP_ADD: begin
                stg_next[0].res = sum_ab[W-1:0];
                stg_next[0].ovf = sum_ab[W] ^ sum_ab[W-1];
            end
            OP_SUB: begin
                stg_next[0].res = dif_ab[W-1:0];
                stg_next[0].ovf = dif_ab[W] ^ dif_ab[W-1];
            end
            OP_INC: begin
                stg_next[0].res = inc_a[W-1:0];
                stg_next[0].ovf = inc_a[W] ^ inc_a[W-1];
            end
            OP_DEC: begin
                stg_next[0].res = dec_a[W-1:0];
                stg_next[0].ovf = dec_a[W] ^ dec_a[W-1];
            end
            OP_DIV:  stg_next[0].dz  = (b == '0);
            OP_LT:   stg_next[0].cmp = lt_ab;
            OP_GT:   stg_next[0].cmp = gt_ab;
            OP_LE:   stg_next[0].cmp = !gt_ab;
            OP_GE:   stg_next[0].cmp = !lt_ab;
            OP_EQ:   stg_next[0].cmp = (a == b);
            OP_NE:   stg_next[0].cmp = (a != b);
            OP_MIN:  stg_next[0].res = gt_ab ? b : a;
            OP_MAX:  stg_next[0].res = lt_ab ? b : a;
            OP_FROM_INT: begin
                stg_next[0].res = a << F;
                stg_next[0].ovf = (a != ((a << F) >>> F));
            end
            OP_TO_INT: stg_next[0].res = a >>> F;
            default: ;
        endcase

        for (int k = 1; k <= Q; k++) begin
            p  = stg_reg[k-1];
            rs = {p.rem, p.num[Q-1]};
            ge = (rs >= {1'b0, p.den});
            stg_next[k]     = p;
            stg_next[k].num = p.num << 1;
            stg_next[k].quo = {p.quo[Q-2:0], ge};
            stg_next[k].rem = ge ? W'(rs - {1'b0, p.den}) : rs[W-1:0];
            if (k == 1) begin
                stg_next[k].prod = {{W{1'b0}}, p.prod[W-1:0]} * {{W{1'b0}}, p.den};
            end else if (k == 2) begin
                stg_next[k].prod = (p.prod >> F)
                    + {{(2*W-1){1'b0}}, p.neg && (p.prod[F-1:0] != '0)};
            end
        end

        p   = stg_reg[Q];
        lim = {{(W+1){1'b0}}, {(W-1){1'b1}}} + {{(2*W-1){1'b0}}, p.neg};
        stg_next[N-1] = p;
        if (p.op == OP_MUL) begin
            stg_next[N-1].ovf = p.prod > lim;
            stg_next[N-1].res = p.neg ? (~p.prod[W-1:0] + {{(W-1){1'b0}}, 1'b1})
                                      : p.prod[W-1:0];
        end else if (p.op == OP_DIV && !p.dz) begin
            stg_next[N-1].ovf = {{(2*W-Q){1'b0}}, p.quo} > lim;
            stg_next[N-1].res = p.neg ? (~p.quo[W-1:0] + {{(W-1){1'b0}}, 1'b1})
                                      : p.quo[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[N-2:0], s_tvalid};
        end
        if (adv) begin
            for (int k = 0; k < N; k++) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign m_tvalid = vld_reg[N-1];
    assign m_tdata  = stg_reg[N-1].res;
    assign m_tuser  = {stg_reg[N-1].dz, stg_reg[N-1].ovf, stg_reg[N-1].cmp};

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> (m_tdata == '0 && !m_tuser[1]))
        else $error("Divide by zero must give a zero result without overflow.");
    a_cmp_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
        else $error("A true comparison must carry a zero result.");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("Output changed during a stall.");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid) |-> s_tready)
        else $error("Input must be ready while the output stage is empty.");
endmodule
`default_nettype wire
